@@ src/wgas_pkg.sv @@
`default_nettype none

package wgas_pkg;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [1:0] {
        STATUS_ENTRY = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef enum logic {
        KIND_QUERY  = 1'b0,
        KIND_MODIFY = 1'b1
    } kind_t;

endpackage

`default_nettype wire

@@ src/weighted_graph_adjacency_store_core.sv @@
`default_nettype none
// A modify transaction writes both directions (one write per direction), no result.
// A query reads the row one cell per cycle, unless held by a stalled result,
// from the single-port weight memory; results leave one per cycle unless stalled.
// An error result waits in S_ERR for a free output. One transaction is in work at a time.
// Reset: async active-low; per-entry valid bits clear at once, so the store reads as empty.
module weighted_graph_adjacency_store_core #(
    parameter int NUM_VERTICES = 8,
    parameter int WEIGHT_BITS  = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [3:0] vertex_a,
    input  wire logic [3:0] vertex_b,
    input  wire logic [7:0] weight,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      neighbor,
    output logic [7:0]      edge_weight,
    output logic [1:0]      status,
    output logic            last
);
    import wgas_pkg::*;

    localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(NUM_VERTICES + 1);
    localparam int SW    = (WEIGHT_BITS < 8) ? WEIGHT_BITS : 8;
    localparam int FW    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD2,
        S_QUERY,
        S_FINISH,
        S_ERR
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     row_reg, row_next;
    logic [AW-1:0]     addr2_reg, addr2_next;
    logic [SW-1:0]     w_reg, w_next;
    logic [CW-1:0]     issue_col_reg, issue_col_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [CW-1:0]     s1_col_reg, s1_col_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [3:0]        pend_nb_reg, pend_nb_next;
    logic [SW-1:0]     pend_w_reg, pend_w_next;
    logic [FW-1:0]     found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        neighbor_reg, neighbor_next;
    logic [7:0]        edge_weight_reg, edge_weight_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic [SW-1:0]     mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [SW-1:0]     rd_data_reg;
    logic              rd_vld_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [SW-1:0]     wdata;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              accept;
    logic              a_ok, b_ok;
    logic              out_free;
    logic [SW-1:0]     rd_word;
    logic              hit, consume, issue_ok;
    logic [AW-1:0]     addr_ab, addr_ba, row_a;

    assign accept   = in_valid && in_ready;
    assign a_ok     = (vertex_a != 4'd0) && (vertex_a <= 4'(NUM_VERTICES));
    assign b_ok     = (vertex_b != 4'd0) && (vertex_b <= 4'(NUM_VERTICES));
    assign out_free = !out_valid_reg || out_ready;
    assign addr_ab  = AW'((32'(vertex_a) - 32'd1) * NUM_VERTICES + (32'(vertex_b) - 32'd1));
    assign addr_ba  = AW'((32'(vertex_b) - 32'd1) * NUM_VERTICES + (32'(vertex_a) - 32'd1));
    assign row_a    = AW'((32'(vertex_a) - 32'd1) * NUM_VERTICES);
    assign rd_addr  = row_reg + AW'(issue_col_reg);

    assign rd_word  = rd_vld_reg ? rd_data_reg : '0;
    assign hit      = s1_valid_reg && (rd_word != '0);
    assign consume  = s1_valid_reg && (!hit || !pend_valid_reg || out_free);
    assign issue_ok = (issue_col_reg != CW'(NUM_VERTICES)) && (!s1_valid_reg || consume);

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        addr2_next       = addr2_reg;
        w_next           = w_reg;
        issue_col_next   = issue_col_reg;
        s1_valid_next    = s1_valid_reg;
        s1_col_next      = s1_col_reg;
        pend_valid_next  = pend_valid_reg;
        pend_nb_next     = pend_nb_reg;
        pend_w_next      = pend_w_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        neighbor_next    = neighbor_reg;
        edge_weight_next = edge_weight_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        we               = 1'b0;
        waddr            = addr_ab;
        wdata            = weight[SW-1:0];
        rd_en            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        if (a_ok)
                        begin
                            row_next        = row_a;
                            issue_col_next  = '0;
                            s1_valid_next   = 1'b0;
                            pend_valid_next = 1'b0;
                            found_next      = '0;
                            state_next      = S_QUERY;
                        end
                        else
                        begin
                            state_next = S_ERR;
                        end
                    end
                    else if (a_ok && b_ok)
                    begin
                        we         = 1'b1;
                        addr2_next = addr_ba;
                        w_next     = weight[SW-1:0];
                        state_next = S_MOD2;
                    end
                    else
                    begin
                        state_next = S_ERR;
                    end
                end
            end

            S_MOD2:
            begin
                we         = 1'b1;
                waddr      = addr2_reg;
                wdata      = w_reg;
                state_next = S_IDLE;
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    neighbor_next    = '0;
                    edge_weight_next = '0;
                    status_next      = STATUS_ERROR;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_QUERY:
            begin
                // previous hit leaves only when a later one shows it is not last
                if (hit && consume && pend_valid_reg)
                begin
                    out_valid_next   = 1'b1;
                    neighbor_next    = pend_nb_reg;
                    edge_weight_next = 8'(pend_w_reg);
                    status_next      = STATUS_ENTRY;
                    last_next        = 1'b0;
                end
                if (hit && consume)
                begin
                    pend_valid_next = 1'b1;
                    pend_nb_next    = 4'(s1_col_reg) + 4'd1;
                    pend_w_next     = rd_word;
                    found_next      = found_reg + FW'(1);
                end
                if (hit && consume && (found_reg == FW'(MAX_RESULTS - 1)))
                begin
                    s1_valid_next = 1'b0;
                    state_next    = S_FINISH;
                end
                else
                begin
                    if (issue_ok)
                    begin
                        rd_en          = 1'b1;
                        issue_col_next = issue_col_reg + CW'(1);
                        s1_valid_next  = 1'b1;
                        s1_col_next    = issue_col_reg;
                    end
                    else if (consume)
                    begin
                        s1_valid_next = 1'b0;
                    end
                    if ((issue_col_reg == CW'(NUM_VERTICES)) && (!s1_valid_reg || consume))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        neighbor_next    = pend_nb_reg;
                        edge_weight_next = 8'(pend_w_reg);
                        status_next      = STATUS_ENTRY;
                    end
                    else
                    begin
                        neighbor_next    = '0;
                        edge_weight_next = '0;
                        status_next      = STATUS_EMPTY;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            row_reg         <= '0;
            addr2_reg       <= '0;
            w_reg           <= '0;
            issue_col_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s1_col_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            pend_nb_reg     <= '0;
            pend_w_reg      <= '0;
            found_reg       <= '0;
            out_valid_reg   <= 1'b0;
            neighbor_reg    <= '0;
            edge_weight_reg <= '0;
            status_reg      <= STATUS_ENTRY;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            addr2_reg       <= addr2_next;
            w_reg           <= w_next;
            issue_col_reg   <= issue_col_next;
            s1_valid_reg    <= s1_valid_next;
            s1_col_reg      <= s1_col_next;
            pend_valid_reg  <= pend_valid_next;
            pend_nb_reg     <= pend_nb_next;
            pend_w_reg      <= pend_w_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
            neighbor_reg    <= neighbor_next;
            edge_weight_reg <= edge_weight_next;
            status_reg      <= status_next;
            last_reg        <= last_next;
        end
    end

    // weight memory, one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // unwritten cells read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign neighbor    = neighbor_reg;
    assign edge_weight = edge_weight_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUERY) |-> !we)
        else $error("memory write during row walk");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FW'(MAX_RESULTS))
        else $error("neighbor count over limit");

    a_nonlast_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (status_reg == STATUS_ENTRY))
        else $error("non-final result without entry status");

    a_modify_second_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_MODIFY) && a_ok && b_ok) |=> (state_reg == S_MOD2))
        else $error("modify missing mirror write");

endmodule

`default_nettype wire
